FILE: rtl/core/cntg_pkg.sv
// Shared constants, types and step functions for the normalisation cube map core.
// Used by every module under rtl/core; depends on nothing.
package cntg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FACE_W    = 3;
  localparam int TEX_W     = 10;
  localparam int CFG_W     = 11;
  localparam int SPAN_W    = 10;
  localparam int Q_W       = 18;   // coordinate quotient, 0..2*ONE
  localparam int MAG_W     = 17;   // component magnitude, 0..ONE
  localparam int SQ_W      = 34;   // squared length, at most 3*ONE*ONE
  localparam int RAD_W     = 36;   // squared length padded to whole digit pairs
  localparam int ROOT_W    = 18;
  localparam int LEN_W     = 17;
  localparam int RQ_W      = 18;
  localparam int PROD_W    = 34;
  localparam int M_W       = 18;
  localparam int ENC_W     = 28;
  localparam int BYTE_W    = 8;

  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = 6;   // 18 quotient / root bits at 3 per stage

  localparam logic [MAG_W-1:0]  FX_ONE    = 17'h10000;
  localparam logic [Q_W-1:0]    Q_ONE     = 18'h10000;
  localparam logic [LEN_W-1:0]  RCP_SEED  = 17'd16384;  // 2^32 >> 18
  localparam logic [CFG_W-1:0]  MIN_SIZE  = 11'd2;
  localparam logic [CFG_W-1:0]  MAX_SIZE  = 11'd1024;
  localparam logic [SPAN_W-1:0] SPAN_RST  = 10'd255;
  localparam logic [BYTE_W-1:0] BYTE_MID  = 8'd127;
  localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'd255;

  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

  typedef struct packed {
    logic                   bad;
    logic [2:0]             neg;
    logic [2:0][MAG_W-1:0]  mag;
  } vec_t;

  typedef struct packed {
    logic [SPAN_W-1:0] rem;
    logic [Q_W-1:0]    q;
  } cdiv_t;

  typedef struct packed {
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  x;
  } sqrt_t;

  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic [RQ_W-1:0]  q;
  } rcp_t;

  // restoring division, three quotient bits
  function automatic cdiv_t cdiv_step(cdiv_t st, logic first_bit, logic [SPAN_W-1:0] d);
    cdiv_t         r;
    logic [SPAN_W:0] t;
    logic          b;
    r = st;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      b = (j == 0) ? first_bit : 1'b0;
      t = {r.rem, b};
      if (t >= {1'b0, d}) begin
        t   = t - {1'b0, d};
        r.q = {r.q[Q_W-2:0], 1'b1};
      end else begin
        r.q = {r.q[Q_W-2:0], 1'b0};
      end
      r.rem = t[SPAN_W-1:0];
    end
    return r;
  endfunction

  // digit-by-digit square root, three result bits
  function automatic sqrt_t sqrt_step(sqrt_t st);
    sqrt_t             r;
    logic [ROOT_W+3:0] t;
    logic [ROOT_W+3:0] trial;
    r = st;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      t     = {r.rem, r.x[RAD_W-1:RAD_W-2]};
      trial = {2'b00, r.root, 2'b01};
      if (t >= trial) begin
        t      = t - trial;
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
      r.rem = t[ROOT_W+1:0];
      r.x   = {r.x[RAD_W-3:0], 2'b00};
    end
    return r;
  endfunction

  // reciprocal division, dividend bits below the seed are all zero
  function automatic rcp_t rcp_step(rcp_t st, logic [LEN_W-1:0] d);
    rcp_t           r;
    logic [LEN_W:0] t;
    r = st;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      t = {r.rem, 1'b0};
      if (t >= {1'b0, d}) begin
        t   = t - {1'b0, d};
        r.q = {r.q[RQ_W-2:0], 1'b1};
      end else begin
        r.q = {r.q[RQ_W-2:0], 1'b0};
      end
      r.rem = t[LEN_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/cntg_coord_div.sv
// Pipelined texel-to-coordinate divider, two lanes (u and v), 3 bits per stage.
// Depends on cntg_pkg.
module cntg_coord_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [cntg_pkg::FACE_W-1:0]     in_face,
  input  logic [cntg_pkg::TEX_W-1:0]      in_u,
  input  logic [cntg_pkg::TEX_W-1:0]      in_v,
  input  logic [cntg_pkg::SPAN_W-1:0]     span,
  output logic                            out_valid,
  output logic [cntg_pkg::FACE_W-1:0]     out_face,
  output logic [cntg_pkg::Q_W-1:0]        out_qu,
  output logic [cntg_pkg::Q_W-1:0]        out_qv
);

  cntg_pkg::cdiv_t                     u_r   [cntg_pkg::DIV_STAGES];
  cntg_pkg::cdiv_t                     v_r   [cntg_pkg::DIV_STAGES];
  cntg_pkg::cdiv_t                     u_nxt [cntg_pkg::DIV_STAGES];
  cntg_pkg::cdiv_t                     v_nxt [cntg_pkg::DIV_STAGES];
  logic [cntg_pkg::FACE_W-1:0]         face_r[cntg_pkg::DIV_STAGES];
  logic [cntg_pkg::DIV_STAGES-1:0]     vld_r;
  cntg_pkg::cdiv_t                     seed_u, seed_v;

  // 2*c<<16 / span: the top bits leave c>>1 as remainder, c[0] enters first
  always_comb begin
    seed_u.rem = {1'b0, in_u[cntg_pkg::TEX_W-1:1]};
    seed_u.q   = '0;
    seed_v.rem = {1'b0, in_v[cntg_pkg::TEX_W-1:1]};
    seed_v.q   = '0;
    u_nxt[0] = cntg_pkg::cdiv_step(seed_u, in_u[0], span);
    v_nxt[0] = cntg_pkg::cdiv_step(seed_v, in_v[0], span);
    for (int s = 1; s < cntg_pkg::DIV_STAGES; s++) begin
      u_nxt[s] = cntg_pkg::cdiv_step(u_r[s-1], 1'b0, span);
      v_nxt[s] = cntg_pkg::cdiv_step(v_r[s-1], 1'b0, span);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[cntg_pkg::DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r       <= u_nxt;
      v_r       <= v_nxt;
      face_r[0] <= in_face;
      for (int s = 1; s < cntg_pkg::DIV_STAGES; s++) begin
        face_r[s] <= face_r[s-1];
      end
    end
  end

  assign out_valid = vld_r[cntg_pkg::DIV_STAGES-1];
  assign out_face  = face_r[cntg_pkg::DIV_STAGES-1];
  assign out_qu    = u_r[cntg_pkg::DIV_STAGES-1].q;
  assign out_qv    = v_r[cntg_pkg::DIV_STAGES-1].q;

endmodule

FILE: rtl/core/cntg_sqrt.sv
// Pipelined integer square root of the squared length, 3 root bits per stage.
// Depends on cntg_pkg.
module cntg_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [cntg_pkg::SQ_W-1:0]    in_len2,
  input  cntg_pkg::vec_t               in_side,
  output logic                         out_valid,
  output logic [cntg_pkg::LEN_W-1:0]   out_len,
  output cntg_pkg::vec_t               out_side
);

  cntg_pkg::sqrt_t                 st_r  [cntg_pkg::DIV_STAGES];
  cntg_pkg::sqrt_t                 st_nxt[cntg_pkg::DIV_STAGES];
  cntg_pkg::vec_t                  side_r[cntg_pkg::DIV_STAGES];
  logic [cntg_pkg::DIV_STAGES-1:0] vld_r;
  cntg_pkg::sqrt_t                 seed;

  always_comb begin
    seed.rem  = '0;
    seed.root = '0;
    seed.x    = {{(cntg_pkg::RAD_W-cntg_pkg::SQ_W){1'b0}}, in_len2};
    st_nxt[0] = cntg_pkg::sqrt_step(seed);
    for (int s = 1; s < cntg_pkg::DIV_STAGES; s++) begin
      st_nxt[s] = cntg_pkg::sqrt_step(st_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[cntg_pkg::DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r      <= st_nxt;
      side_r[0] <= in_side;
      for (int s = 1; s < cntg_pkg::DIV_STAGES; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // root of a valid face lies in ONE..sqrt(3)*ONE, so 17 bits suffice
  assign out_valid = vld_r[cntg_pkg::DIV_STAGES-1];
  assign out_len   = st_r[cntg_pkg::DIV_STAGES-1].root[cntg_pkg::LEN_W-1:0];
  assign out_side  = side_r[cntg_pkg::DIV_STAGES-1];

endmodule

FILE: rtl/core/cntg_recip.sv
// Pipelined reciprocal ONE*ONE/len, 3 quotient bits per stage.
// Depends on cntg_pkg.
module cntg_recip (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [cntg_pkg::LEN_W-1:0]   in_len,
  input  cntg_pkg::vec_t               in_side,
  output logic                         out_valid,
  output logic [cntg_pkg::MAG_W-1:0]   out_rsq,
  output cntg_pkg::vec_t               out_side
);

  cntg_pkg::rcp_t                    st_r  [cntg_pkg::DIV_STAGES];
  cntg_pkg::rcp_t                    st_nxt[cntg_pkg::DIV_STAGES];
  logic [cntg_pkg::LEN_W-1:0]        len_r [cntg_pkg::DIV_STAGES];
  cntg_pkg::vec_t                    side_r[cntg_pkg::DIV_STAGES];
  logic [cntg_pkg::DIV_STAGES-1:0]   vld_r;
  cntg_pkg::rcp_t                    seed;

  always_comb begin
    seed.rem  = cntg_pkg::RCP_SEED;
    seed.q    = '0;
    st_nxt[0] = cntg_pkg::rcp_step(seed, in_len);
    for (int s = 1; s < cntg_pkg::DIV_STAGES; s++) begin
      st_nxt[s] = cntg_pkg::rcp_step(st_r[s-1], len_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[cntg_pkg::DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r      <= st_nxt;
      len_r[0]  <= in_len;
      side_r[0] <= in_side;
      for (int s = 1; s < cntg_pkg::DIV_STAGES; s++) begin
        len_r[s]  <= len_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = vld_r[cntg_pkg::DIV_STAGES-1];
  assign out_rsq   = st_r[cntg_pkg::DIV_STAGES-1].q[cntg_pkg::MAG_W-1:0];
  assign out_side  = side_r[cntg_pkg::DIV_STAGES-1];

endmodule

FILE: rtl/core/cubemap_normal_texel_gen_core.sv
// Top level of the normalisation cube map texel generator.
// Depends on cntg_pkg, cntg_coord_div, cntg_sqrt and cntg_recip.

// Takes one (face, u, v) transaction per clock unless stalled and returns the RGB byte
// encoding of the unit direction through that texel, one result per input, in order. Each
// passes the input clamp, six coordinate divider stages, vector build, squaring, sum,
// six square-root stages, six reciprocal stages, normalising multiply, encode and the
// output register. A single skid entry behind the pipeline lets the input keep
// flowing for one transaction after the output stalls; the pipeline then
// holds until the skid entry drains. face_size is sampled live and must only be written
// while no transaction is in flight. Faces six and seven return 127 on all channels.
module cubemap_normal_texel_gen_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [10:0] cfg_wdata,   // face_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // face[2:0], texel_u[12:3], texel_v[22:13], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // red[7:0], green[15:8], blue[23:16]
);

  localparam int MW = cntg_pkg::MAG_W;
  localparam int BW = cntg_pkg::BYTE_W;

  logic [cntg_pkg::SPAN_W-1:0] span_r;
  logic [cntg_pkg::CFG_W-1:0]  size_sat;
  logic                        en;
  logic                        skid_v_r, out_v_r, out_free;
  logic [23:0]                 skid_r, out_r;

  // configuration: store size-1 after saturation
  always_comb begin
    size_sat = cfg_wdata;
    if (cfg_wdata < cntg_pkg::MIN_SIZE) size_sat = cntg_pkg::MIN_SIZE;
    if (cfg_wdata > cntg_pkg::MAX_SIZE) size_sat = cntg_pkg::MAX_SIZE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= cntg_pkg::SPAN_RST;
    end else if (cfg_wen) begin
      span_r <= cntg_pkg::SPAN_W'(size_sat - 11'd1);
    end
  end

  assign en        = !skid_v_r;
  assign in_tready = en;

  // stage 0: clamp texel indices
  logic                          s0_v_r;
  logic [cntg_pkg::FACE_W-1:0]   s0_face_r;
  logic [cntg_pkg::TEX_W-1:0]    s0_u_r, s0_v_idx_r, u_cl, v_cl;

  always_comb begin
    u_cl = (in_tdata[12:3]  > span_r) ? span_r : in_tdata[12:3];
    v_cl = (in_tdata[22:13] > span_r) ? span_r : in_tdata[22:13];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_face_r  <= in_tdata[2:0];
      s0_u_r     <= u_cl;
      s0_v_idx_r <= v_cl;
    end
  end

  logic                         dv_v;
  logic [cntg_pkg::FACE_W-1:0]  dv_face;
  logic [cntg_pkg::Q_W-1:0]     dv_qu, dv_qv;

  cntg_coord_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s0_v_r),
    .in_face  (s0_face_r),
    .in_u     (s0_u_r),
    .in_v     (s0_v_idx_r),
    .span     (span_r),
    .out_valid(dv_v),
    .out_face (dv_face),
    .out_qu   (dv_qu),
    .out_qv   (dv_qv)
  );

  // vector build: sign and magnitude per component
  logic            sn, tn;
  logic [MW-1:0]   sm, tm;
  cntg_pkg::vec_t  vec_nxt, vec_r;
  logic            vec_v_r;
  logic [cntg_pkg::Q_W-1:0] su_d, tv_d;

  always_comb begin
    sn   = dv_qu < cntg_pkg::Q_ONE;
    tn   = dv_qv < cntg_pkg::Q_ONE;
    su_d = sn ? (cntg_pkg::Q_ONE - dv_qu) : (dv_qu - cntg_pkg::Q_ONE);
    tv_d = tn ? (cntg_pkg::Q_ONE - dv_qv) : (dv_qv - cntg_pkg::Q_ONE);
    sm   = su_d[MW-1:0];
    tm   = tv_d[MW-1:0];
    vec_nxt.bad = 1'b0;
    case (dv_face)
      cntg_pkg::FACE_POS_X: begin
        vec_nxt.mag = {sm, tm, cntg_pkg::FX_ONE};
        vec_nxt.neg = {~sn, ~tn, 1'b0};
      end
      cntg_pkg::FACE_NEG_X: begin
        vec_nxt.mag = {sm, tm, cntg_pkg::FX_ONE};
        vec_nxt.neg = {sn, ~tn, 1'b1};
      end
      cntg_pkg::FACE_POS_Y: begin
        vec_nxt.mag = {tm, cntg_pkg::FX_ONE, sm};
        vec_nxt.neg = {tn, 1'b0, sn};
      end
      cntg_pkg::FACE_NEG_Y: begin
        vec_nxt.mag = {tm, cntg_pkg::FX_ONE, sm};
        vec_nxt.neg = {~tn, 1'b1, sn};
      end
      cntg_pkg::FACE_POS_Z: begin
        vec_nxt.mag = {cntg_pkg::FX_ONE, tm, sm};
        vec_nxt.neg = {1'b0, ~tn, sn};
      end
      cntg_pkg::FACE_NEG_Z: begin
        vec_nxt.mag = {cntg_pkg::FX_ONE, tm, sm};
        vec_nxt.neg = {1'b1, ~tn, ~sn};
      end
      default: begin
        vec_nxt.mag = '0;
        vec_nxt.neg = '0;
        vec_nxt.bad = 1'b1;
      end
    endcase
  end

  // squaring, then sum
  logic                                  sq_v_r, sum_v_r;
  logic [2:0][cntg_pkg::SQ_W-1:0]        sq_r;
  cntg_pkg::vec_t                        sq_side_r, sum_side_r;
  logic [cntg_pkg::SQ_W-1:0]             sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_v_r <= 1'b0;
      sq_v_r  <= 1'b0;
      sum_v_r <= 1'b0;
    end else if (en) begin
      vec_v_r <= dv_v;
      sq_v_r  <= vec_v_r;
      sum_v_r <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r      <= vec_nxt;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= vec_r.mag[k] * vec_r.mag[k];
      end
      sq_side_r  <= vec_r;
      sum_r      <= sq_r[0] + sq_r[1] + sq_r[2];
      sum_side_r <= sq_side_r;
    end
  end

  logic                         rt_v;
  logic [cntg_pkg::LEN_W-1:0]   rt_len;
  cntg_pkg::vec_t               rt_side;

  cntg_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sum_v_r),
    .in_len2  (sum_r),
    .in_side  (sum_side_r),
    .out_valid(rt_v),
    .out_len  (rt_len),
    .out_side (rt_side)
  );

  logic                  rc_v;
  logic [MW-1:0]         rc_rsq;
  cntg_pkg::vec_t        rc_side;

  cntg_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (rt_v),
    .in_len   (rt_len),
    .in_side  (rt_side),
    .out_valid(rc_v),
    .out_rsq  (rc_rsq),
    .out_side (rc_side)
  );

  // normalise: m = |c| * rsq >> 16
  logic                              mul_v_r, enc_v_r;
  logic [2:0][cntg_pkg::PROD_W-1:0]  prod;
  logic [2:0][cntg_pkg::M_W-1:0]     m_r;
  logic [2:0]                        mneg_r;
  logic                              mbad_r;
  logic [2:0][BW-1:0]                rgb;
  logic [23:0]                       enc_r;
  logic signed [cntg_pkg::M_W+1:0]   t;
  logic signed [cntg_pkg::ENC_W-1:0] e;
  logic [cntg_pkg::ENC_W-1:0]        eb;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = rc_side.mag[k] * rc_rsq;
    end
  end

  // encode (n + ONE) * 255 >> 17, clamped
  always_comb begin
    t   = '0;
    e   = '0;
    eb  = '0;
    rgb = '0;
    for (int k = 0; k < 3; k++) begin
      if (mneg_r[k]) begin
        t = $signed({3'b000, cntg_pkg::FX_ONE}) - $signed({2'b00, m_r[k]});
      end else begin
        t = $signed({3'b000, cntg_pkg::FX_ONE}) + $signed({2'b00, m_r[k]});
      end
      e  = (cntg_pkg::ENC_W'(t) <<< 8) - cntg_pkg::ENC_W'(t);
      eb = e >>> (cntg_pkg::FRAC_BITS + 1);
      if (e < 0) begin
        rgb[k] = '0;
      end else if (eb > cntg_pkg::ENC_W'(cntg_pkg::BYTE_MAX)) begin
        rgb[k] = cntg_pkg::BYTE_MAX;
      end else begin
        rgb[k] = eb[BW-1:0];
      end
      if (mbad_r) rgb[k] = cntg_pkg::BYTE_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      enc_v_r <= 1'b0;
    end else if (en) begin
      mul_v_r <= rc_v;
      enc_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_r[k] <= prod[k][cntg_pkg::PROD_W-1:cntg_pkg::FRAC_BITS];
      end
      mneg_r <= rc_side.neg;
      mbad_r <= rc_side.bad;
      enc_r  <= {rgb[2], rgb[1], rgb[0]};
    end
  end

  // output register with one skid entry
  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_free) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (enc_v_r) begin
      if (out_free) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_free) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_free) out_r <= skid_r;
    end else if (enc_v_r) begin
      if (out_free) begin
        out_r <= enc_r;
      end else begin
        skid_r <= enc_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule

FILE: verif/cubemap_normal_texel_gen_core_tb.sv
// Testbench for cubemap_normal_texel_gen_core: random and directed texels checked against
// a behavioural normal-map predictor. Depends on cntg_pkg and the core RTL.
module cubemap_normal_texel_gen_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // packed from the lowest bit up: face, u, v
  typedef struct packed {
    logic [9:0] v;
    logic [9:0] u;
    logic [2:0] face;
  } texel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  texel_t      pending_texels[$];
  logic [23:0] expected_rgb[$];
  logic [10:0] face_size_q = 11'd256;
  int          mismatches = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  bit          in_taken = 1'b0;

  cubemap_normal_texel_gen_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint face_coord(longint unsigned c, longint unsigned span);
    return longint'(((2 * c) << 16) / span) - 65536;
  endfunction

  function automatic logic [7:0] encode_byte(longint n);
    longint e = (n + 65536) * 255;
    longint b;
    if (e < 0) return 8'd0;
    b = e >>> 17;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  // expected RGB for one texel at the current face size
  function automatic logic [23:0] normal_rgb(texel_t t);
    longint unsigned size, span, u, v, len2, len, a, rsq;
    longint s, tc, m;
    longint dir[3];
    logic [23:0] rgb;
    size = face_size_q;
    if (size < 2) size = 2;
    if (size > 1024) size = 1024;
    span = size - 1;
    u = (t.u > span) ? span : t.u;
    v = (t.v > span) ? span : t.v;
    if (t.face > cntg_pkg::FACE_NEG_Z) return {3{cntg_pkg::BYTE_MID}};
    s  = face_coord(u, span);
    tc = face_coord(v, span);
    case (t.face)
      cntg_pkg::FACE_POS_X: dir = '{65536, -tc, -s};
      cntg_pkg::FACE_NEG_X: dir = '{-65536, -tc, s};
      cntg_pkg::FACE_POS_Y: dir = '{s, 65536, tc};
      cntg_pkg::FACE_NEG_Y: dir = '{s, -65536, -tc};
      cntg_pkg::FACE_POS_Z: dir = '{s, -tc, 65536};
      default:              dir = '{-s, -tc, -65536};
    endcase
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      a = (dir[k] < 0) ? -dir[k] : dir[k];
      len2 += a * a;
    end
    len = isqrt(len2);
    if (len == 0) len = 1;
    rsq = (64'd1 << 32) / len;
    for (int k = 0; k < 3; k++) begin
      a = (dir[k] < 0) ? -dir[k] : dir[k];
      m = longint'((a * rsq) >> 16);
      rgb[8*k +: 8] = encode_byte((dir[k] < 0) ? -m : m);
    end
    return rgb;
  endfunction

  // handshake seen at the last rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // sender: bursts and gaps, one transaction per handshake
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_texels.size() > 0) begin
        in_tdata  <= {1'b0, pending_texels.pop_front()};
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: phases of no, light and heavy back-pressure
  always @(negedge clk) begin
    int phase;
    phase = int'(($time / 2000) % 3);
    if (!rst_n) out_tready <= 1'b0;
    else if (phase == 0) out_tready <= 1'b1;
    else if (phase == 1) out_tready <= ($urandom_range(3, 0) != 0);
    else out_tready <= ($urandom_range(3, 0) == 0);
  end

  // predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    logic [23:0] exp_rgb;
    if (rst_n && in_tvalid && in_tready)
      expected_rgb.push_back(normal_rgb(texel_t'(in_tdata[22:0])));
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_rgb = expected_rgb.pop_front();
        for (int k = 0; k < 3; k++)
          if (exp_rgb[8*k +: 8] !== out_tdata[8*k +: 8]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("channel %0d: expected %0d got %0d", k, exp_rgb[8*k +: 8],
                       out_tdata[8*k +: 8]);
          end
      end
    end
  end

  task automatic push_texel(logic [2:0] f, logic [9:0] u, logic [9:0] v);
    texel_t t;
    t.face = f;
    t.u = u;
    t.v = v;
    pending_texels.push_back(t);
  endtask

  task automatic drain_all();
    while (pending_texels.size() > 0 || in_tvalid || expected_rgb.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(logic [10:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= val;
    face_size_q = val;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    logic [10:0] sizes[7];
    logic [10:0] sz;
    sizes = '{11'd256, 11'd0, 11'd2, 11'd1024, 11'd2047, 11'd3, 11'd17};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every face at two opposite corners and centre, bad faces, out-of-edge texels
    for (int f = 0; f < 8; f++) begin
      push_texel(3'(f), 10'd0, 10'd0);
      push_texel(3'(f), 10'd255, 10'd255);
      push_texel(3'(f), 10'd128, 10'd128);
    end
    push_texel(cntg_pkg::FACE_POS_Z, 10'h3FF, 10'h3FF);
    drain_all();

    foreach (sizes[i]) begin
      write_size(sizes[i]);
      sz = (sizes[i] < 2) ? 11'd2 : (sizes[i] > 1024) ? 11'd1024 : sizes[i];
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(9, 0) == 0)
          push_texel(3'($urandom_range(7, 0)), 10'($urandom_range(1023, 0)),
                     10'($urandom_range(1023, 0)));
        else
          push_texel(3'($urandom_range(5, 0)), 10'($urandom_range(sz - 1, 0)),
                     10'($urandom_range(sz - 1, 0)));
      end
      drain_all();
    end
    if (mismatches == 0) $display("cubemap_normal_texel_gen_core test passed");
    else $display("cubemap_normal_texel_gen_core test failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("cubemap_normal_texel_gen_core test failed");
    $finish;
  end

endmodule
